[rtl/core/rotate_bits_along_mask_unit_macros.svh]
// Assertion macros used by the checker of the rotate-along-mask unit.
`ifndef ROTATE_BITS_ALONG_MASK_UNIT_MACROS_SVH
`define ROTATE_BITS_ALONG_MASK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define RBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbm: assertion failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define RBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbm: assertion failed");

`endif

[rtl/core/rbm_pkg.sv]
// Package of the rotate-along-mask unit: widths, stage word type, rotation helper.
`default_nettype none

package rbm_pkg;

    // Number of positions handled; one pipeline stage per pass
    localparam int NUM_POSITIONS = 9;
    // Width of the set fields on the channels
    localparam int FIELD_W = 9;
    // Width of a rotation amount, able to hold NUM_POSITIONS itself
    localparam int AMT_W = $clog2(NUM_POSITIONS + 1);

    typedef logic [NUM_POSITIONS-1:0] pos_t;
    typedef logic [AMT_W-1:0] amt_t;

    // Word carried between the pass stages
    typedef struct packed {
        logic up;      // 1: rotate toward higher positions
        pos_t bits;    // selected bits not yet placed
        pos_t mask;    // positions still free
        pos_t result;  // positions taken so far
    } stage_t;

    // Circular rotation within NUM_POSITIONS bits, amount 1..NUM_POSITIONS
    function automatic pos_t rot(pos_t x, amt_t a, logic up);
        logic [2*NUM_POSITIONS-1:0] w;
        logic [2*NUM_POSITIONS-1:0] s;
        pos_t r;
        w = {x, x};
        if (up)
        begin
            s = w << a;
            r = s[2*NUM_POSITIONS-1:NUM_POSITIONS];
        end
        else
        begin
            s = w >> a;
            r = s[NUM_POSITIONS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rbm_in_if.sv]
// Input channel of the rotate-along-mask unit: direction, selected set, allowed mask.
`default_nettype none

interface rbm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [rbm_pkg::FIELD_W-1:0]  selected_set;
    logic [rbm_pkg::FIELD_W-1:0]  allowed_mask;

    modport source (output valid, kind, selected_set, allowed_mask, input ready);
    modport sink   (input valid, kind, selected_set, allowed_mask, output ready);
endinterface

`default_nettype wire

[rtl/core/rbm_out_if.sv]
// Output channel of the rotate-along-mask unit: the moved set.
`default_nettype none

interface rbm_out_if;
    logic                         valid;
    logic                         ready;
    logic [rbm_pkg::FIELD_W-1:0]  moved_set;

    modport source (output valid, moved_set, input ready);
    modport sink   (input valid, moved_set, output ready);
endinterface

`default_nettype wire

[rtl/core/rotate_bits_along_mask_unit.sv]
// Top level of the rotate-along-mask unit: input preparation and the chain of pass stages.
//
//  channel | dir | fields                              | handshake
//  --------+-----+-------------------------------------+------------
//  item    | in  | kind, selected_set, allowed_mask    | valid/ready
//  result  | out | moved_set                           | valid/ready
//
// One pass per stage, NUM_POSITIONS stages, each one a register.
// A new word is taken every cycle while results are taken; the pass stage chain sets the rate.
// Reset clears only the stage valid bits; data registers are not reset.
// A stalled result holds in the last stage; each stage holds while the one after is full.
`default_nettype none

module rotate_bits_along_mask_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rbm_in_if.sink     item,
    rbm_out_if.source  result
);

    localparam int N = rbm_pkg::NUM_POSITIONS;

    logic            stage_valid [N+1];
    logic            stage_ready [N+1];
    rbm_pkg::stage_t stage_data  [N+1];
    rbm_pkg::pos_t   in_bits;
    rbm_pkg::pos_t   in_mask;

    // Trim to the position count; an empty mask returns the set unchanged
    assign in_bits = rbm_pkg::pos_t'(item.selected_set);
    assign in_mask = rbm_pkg::pos_t'(item.allowed_mask);

    always_comb
    begin
        stage_data[0].up   = !item.kind;
        stage_data[0].mask = in_mask;
        if (in_mask == '0)
        begin
            stage_data[0].bits   = '0;
            stage_data[0].result = in_bits;
        end
        else
        begin
            stage_data[0].bits   = in_bits;
            stage_data[0].result = '0;
        end
    end

    assign stage_valid[0] = item.valid;
    assign item.ready     = stage_ready[0];

    // Pass stages
    for (genvar g = 0; g < N; g++)
    begin : g_pass
        rbm_pass u_pass (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[g]),
            .up_ready (stage_ready[g]),
            .up_data  (stage_data[g]),
            .dn_valid (stage_valid[g+1]),
            .dn_ready (stage_ready[g+1]),
            .dn_data  (stage_data[g+1])
        );
    end

    assign result.valid     = stage_valid[N];
    assign stage_ready[N]   = result.ready;
    assign result.moved_set = rbm_pkg::FIELD_W'(stage_data[N].result);

endmodule

`default_nettype wire

[rtl/core/rbm_pass.sv]
// One pass stage: finds the smallest landing rotation, places the landed bits, registers.
`default_nettype none

module rbm_pass (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire rbm_pkg::stage_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output rbm_pkg::stage_t      dn_data
);

    rbm_pkg::pos_t   cand [rbm_pkg::NUM_POSITIONS];
    rbm_pkg::pos_t   back [rbm_pkg::NUM_POSITIONS];
    rbm_pkg::pos_t   hit;
    rbm_pkg::pos_t   first;
    rbm_pkg::pos_t   found;
    rbm_pkg::pos_t   landed;
    rbm_pkg::stage_t data_next;
    rbm_pkg::stage_t data_reg;
    logic            vld_reg;
    logic            load;

    // Every rotation amount tried side by side; back[] is the landed source bits
    always_comb
    begin
        for (int a = 0; a < rbm_pkg::NUM_POSITIONS; a++)
        begin
            cand[a] = rbm_pkg::rot(up_data.bits, rbm_pkg::amt_t'(a + 1), up_data.up)
                      & up_data.mask;
            back[a] = rbm_pkg::rot(cand[a], rbm_pkg::amt_t'(a + 1), !up_data.up);
            hit[a]  = |cand[a];
        end
    end

    // Smallest amount wins: isolate lowest set bit of the hit vector
    assign first = hit & (~hit + rbm_pkg::pos_t'(1));

    always_comb
    begin
        found  = '0;
        landed = '0;
        for (int a = 0; a < rbm_pkg::NUM_POSITIONS; a++)
        begin
            if (first[a])
            begin
                found  = found | cand[a];
                landed = landed | back[a];
            end
        end
    end

    // Nothing lands when bits or mask is empty, so the word passes unchanged
    always_comb
    begin
        data_next.up     = up_data.up;
        data_next.bits   = up_data.bits ^ landed;
        data_next.mask   = up_data.mask ^ found;
        data_next.result = up_data.result | found;
    end

    // Stage holds while its word is unread downstream
    assign load     = !vld_reg || dn_ready;
    assign up_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

[rtl/core/rbm_checker.sv]
// Port checker of the rotate-along-mask unit and its bind to the top level.
`default_nettype none
`include "rotate_bits_along_mask_unit_macros.svh"

module rbm_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        item_ready,
    input wire logic                        result_valid,
    input wire logic                        result_ready,
    input wire logic [rbm_pkg::FIELD_W-1:0] moved_set
);

    // A taken result frees every stage behind it
    `RBM_ASSERT_NOW(a_ready_flows, clk, rst_n, result_ready, item_ready)

    // Nothing comes out in the first cycle after reset
    `RBM_ASSERT_NOW(a_empty_after_reset, clk, rst_n, !$past(rst_n), !result_valid)

    // A stalled result stays offered
    `RBM_ASSERT_NEXT(a_valid_holds, clk, rst_n, result_valid && !result_ready, result_valid)

    // A stalled result keeps its value
    `RBM_ASSERT_NEXT(a_data_holds, clk, rst_n, result_valid && !result_ready, $stable(moved_set))

endmodule

bind rotate_bits_along_mask_unit rbm_checker u_rbm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .moved_set    (result.moved_set)
);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench of the rotate-along-mask unit: directed table, random words, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [rbm_pkg::FIELD_W-1:0] field_t;

    // One row of the directed table; known rows carry a hand-read expectation
    typedef struct packed {
        logic   kind;
        field_t sel;
        field_t allow;
        logic   known;
        field_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        // empty mask returns the set unchanged
        '{1'b0, 9'h000, 9'h000, 1'b1, 9'h000},
        '{1'b0, 9'h1FF, 9'h000, 1'b1, 9'h1FF},
        '{1'b1, 9'h0A5, 9'h000, 1'b1, 9'h0A5},
        // empty selection with a live mask
        '{1'b0, 9'h000, 9'h1FF, 1'b1, 9'h000},
        '{1'b1, 9'h000, 9'h1FF, 1'b1, 9'h000},
        // single bits into a full mask, both directions, with wrap
        '{1'b0, 9'h001, 9'h1FF, 1'b1, 9'h002},
        '{1'b1, 9'h001, 9'h1FF, 1'b1, 9'h100},
        '{1'b0, 9'h100, 9'h1FF, 1'b1, 9'h001},
        '{1'b1, 9'h100, 9'h1FF, 1'b1, 9'h080},
        '{1'b0, 9'h1FF, 9'h1FF, 1'b1, 9'h1FF},
        '{1'b1, 9'h1FF, 9'h1FF, 1'b1, 9'h1FF},
        // full rotation: a bit lands back on its own position
        '{1'b0, 9'h001, 9'h001, 1'b1, 9'h001},
        '{1'b1, 9'h010, 9'h010, 1'b1, 9'h010},
        // longest partial rotations, then one-step moves of several bits
        '{1'b0, 9'h001, 9'h100, 1'b1, 9'h100},
        '{1'b1, 9'h001, 9'h002, 1'b1, 9'h002},
        '{1'b0, 9'h1FF, 9'h001, 1'b1, 9'h001},
        '{1'b0, 9'h003, 9'h1FF, 1'b1, 9'h006},
        // multi-pass cases left to the predictor
        '{1'b0, 9'h0F0, 9'h00F, 1'b0, 9'h000},
        '{1'b1, 9'h155, 9'h0AA, 1'b0, 9'h000},
        '{1'b0, 9'h1FF, 9'h155, 1'b0, 9'h000},
        '{1'b1, 9'h003, 9'h180, 1'b0, 9'h000},
        '{1'b0, 9'h111, 9'h0C3, 1'b0, 9'h000},
        '{1'b1, 9'h1FE, 9'h1FE, 1'b0, 9'h000}
    };

    localparam int RANDOM_WORDS = 1950;
    localparam int DRAIN_CYCLES = 2 * rbm_pkg::NUM_POSITIONS + 4;

    logic clk;
    logic rst_n;

    rbm_in_if  item_ch ();
    rbm_out_if result_ch ();

    rotate_bits_along_mask_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Expected moved sets in order, and per-word typed expectations from the driver
    field_t moved_q [$];
    logic   typed_known_q [$];
    field_t typed_want_q [$];

    int  failures;
    int  results_seen;
    int  directed_sent;
    int  random_sent;
    int  drained_waits;
    bit  steady;

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Circular rotation within NUM_POSITIONS bits
    function automatic field_t spin(field_t x, int amt, bit up);
        logic [31:0] w;
        logic [31:0] all_pos;
        int a;
        all_pos = (32'd1 << rbm_pkg::NUM_POSITIONS) - 32'd1;
        w = 32'(x) & all_pos;
        a = amt % rbm_pkg::NUM_POSITIONS;
        if (a != 0)
        begin
            if (up)
                w = ((w << a) | (w >> (rbm_pkg::NUM_POSITIONS - a))) & all_pos;
            else
                w = ((w >> a) | (w << (rbm_pkg::NUM_POSITIONS - a))) & all_pos;
        end
        return field_t'(w);
    endfunction

    // Predicts the moved set for one word
    function automatic field_t predict_moved(logic kind, field_t sel, field_t allow);
        bit     up;
        field_t bits;
        field_t free;
        field_t taken;
        field_t hit;
        int     amt;
        bit     done;
        up = (kind == 1'b0);
        bits = sel;
        free = allow;
        taken = '0;
        if (free == '0)
            return bits;
        done = 1'b0;
        for (int pass = 0; pass < rbm_pkg::NUM_POSITIONS; pass++)
        begin
            if (!done)
            begin
                if (free == '0 || bits == '0)
                    done = 1'b1;
                else
                begin
                    hit = '0;
                    amt = 0;
                    for (int a = 1; a <= rbm_pkg::NUM_POSITIONS; a++)
                    begin
                        if (hit == '0)
                        begin
                            hit = spin(bits, a, up) & free;
                            amt = a;
                        end
                    end
                    if (hit == '0)
                        done = 1'b1;
                    else
                    begin
                        bits = bits ^ spin(hit, amt, !up);
                        free = free ^ hit;
                        taken = taken | hit;
                    end
                end
            end
        end
        return taken;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offers one word, holding valid until it is taken
    task automatic send_word(logic kind, field_t sel, field_t allow, logic known,
                             field_t want);
        int gap;
        gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        typed_known_q.push_back(known);
        typed_want_q.push_back(want);
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.selected_set <= sel;
        item_ch.allowed_mask <= allow;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Result side: ready with random stalls, held high in steady stretches
    initial
    begin
        logic lvl;
        int   hold;
        result_ch.ready = 1'b0;
        lvl = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || steady)
                result_ch.ready <= rst_n;
            else
            begin
                if (hold == 0)
                begin
                    lvl = ($urandom_range(0, 2) != 0);
                    hold = lvl ? $urandom_range(1, 10) : idle_len() + 1;
                end
                result_ch.ready <= lvl;
                hold--;
            end
        end
    end

    // Monitor: check each taken result, then record each taken word
    always @(posedge clk)
    begin
        field_t exp_set;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (moved_q.size() == 0)
            begin
                $error("moved_set: result %h with no pending expectation",
                       result_ch.moved_set);
                failures++;
            end
            else
            begin
                exp_set = moved_q.pop_front();
                if (result_ch.moved_set !== exp_set)
                begin
                    $error("moved_set mismatch: expected %h, actual %h",
                           exp_set, result_ch.moved_set);
                    failures++;
                end
            end
        end
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            if (typed_known_q.pop_front())
            begin
                exp_set = typed_want_q.pop_front();
                moved_q.push_back(exp_set);
            end
            else
            begin
                exp_set = typed_want_q.pop_front();
                moved_q.push_back(predict_moved(item_ch.kind, item_ch.selected_set,
                                                item_ch.allowed_mask));
            end
        end
    end

    // Stimulus: reset, directed table, random words, drain
    initial
    begin
        int     r;
        logic   kind;
        field_t sel;
        field_t allow;
        failures = 0;
        results_seen = 0;
        directed_sent = 0;
        random_sent = 0;
        drained_waits = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.kind = 1'b0;
        item_ch.selected_set = '0;
        item_ch.allowed_mask = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_word(DIR_TABLE[i].kind, DIR_TABLE[i].sel, DIR_TABLE[i].allow,
                      DIR_TABLE[i].known, DIR_TABLE[i].want);
            directed_sent++;
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // steady stretches with no idling on either side
            steady = ((i % 400) >= 300);
            // once, the sender holds off until every result is back
            if (i == RANDOM_WORDS / 2)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
                while (moved_q.size() != 0)
                    @(posedge clk);
                drained_waits++;
            end
            kind = 1'($urandom_range(0, 1));
            sel = field_t'($urandom_range(0, (1 << rbm_pkg::FIELD_W) - 1));
            allow = field_t'($urandom_range(0, (1 << rbm_pkg::FIELD_W) - 1));
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                // sparse mask: few targets, many passes
                allow = allow & field_t'($urandom_range(0, (1 << rbm_pkg::FIELD_W) - 1));
                if (allow == '0)
                    allow = field_t'(1) << $urandom_range(0, rbm_pkg::FIELD_W - 1);
            end
            else if (r < 55)
                // sparse selection
                sel = sel & field_t'($urandom_range(0, (1 << rbm_pkg::FIELD_W) - 1));
            else if (r < 65)
                // single bit onto a single position
            begin
                sel = field_t'(1) << $urandom_range(0, rbm_pkg::FIELD_W - 1);
                allow = field_t'(1) << $urandom_range(0, rbm_pkg::FIELD_W - 1);
            end
            else if (r < 75)
                allow = '0;
            else if (r < 80)
                sel = '0;
            send_word(kind, sel, allow, 1'b0, '0);
            random_sent++;
        end
        steady = 1'b0;
        @(negedge clk);
        item_ch.valid <= 1'b0;

        while (moved_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d directed and %0d random words, %0d results checked, %0d full drain(s),",
                 directed_sent, random_sent, results_seen, drained_waits);
        $display("both directions, empty mask and selection, wraps and full rotations.");
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
